// File: src/spf_pkg.sv
// Shared types and constants for the scanline polygon span fill block.
// No dependencies.
`default_nettype none
package spf_pkg;
	typedef struct packed {
		logic start_scan;
		logic start_edge;
		logic start_sort;
		logic emit;
	} spf_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic edge_done;
		logic sort_done;
	} spf_sts_t;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_FILL  = 1'b1;
endpackage
`default_nettype wire

// File: src/spf_if.sv
// Valid/ready channel interface with a parameterized payload.
// Depends on nothing.
`default_nettype none
interface spf_if #(parameter int W = 8);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/spf_ctrl.sv
// Controller state machine for the span fill block.
// Depends on spf_pkg.
`default_nettype none
module spf_ctrl import spf_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic fill_req,
	input  wire logic need_scan,
	input  wire logic out_free,
	input  wire logic emit_more,
	input  wire spf_sts_t sts,
	output spf_cmd_t cmd,
	output logic busy
);
	localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_EDGE = 3'd2,
		S_SORT = 3'd3, S_EMIT = 3'd4;
	logic [2:0] state_q;

	always_comb begin
		cmd = '0;
		cmd.start_scan = (state_q == S_IDLE) && fill_req && need_scan;
		cmd.start_edge = (state_q == S_IDLE) && fill_req && !need_scan
			|| (state_q == S_SCAN) && sts.scan_done;
		cmd.start_sort = (state_q == S_EDGE) && sts.edge_done;
		cmd.emit = (state_q == S_EMIT) && out_free;
		busy = (state_q != S_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (cmd.start_scan) state_q <= S_SCAN;
					else if (cmd.start_edge) state_q <= S_EDGE;
				S_SCAN: if (sts.scan_done) state_q <= S_EDGE;
				S_EDGE: if (sts.edge_done) state_q <= S_SORT;
				S_SORT: if (sts.sort_done) state_q <= S_EMIT;
				S_EMIT: if (cmd.emit && !emit_more) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: src/spf_dp.sv
// Datapath: vertex store, line range scan, edge crossings with a serial
// divider, odd-even sort of the crossings and span emission. Depends on spf_pkg.
`default_nettype none
module spf_dp import spf_pkg::*; #(
	parameter int MAX_VERTICES = 16,
	parameter int COORD_BITS = 10
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire logic [3:0] wr_idx,
	input  wire logic [COORD_BITS-1:0] wr_x,
	input  wire logic [COORD_BITS-1:0] wr_y,
	input  wire logic [4:0] vcount,
	input  wire spf_cmd_t cmd,
	output spf_sts_t sts,
	output logic need_scan,
	output logic emit_more,
	output logic [COORD_BITS-1:0] o_y,
	output logic [COORD_BITS-1:0] o_xs,
	output logic [COORD_BITS-1:0] o_xe,
	output logic o_sv,
	output logic o_last,
	output logic o_done
);
	localparam int IW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int DW = COORD_BITS + 1;
	localparam int NW = 2 * COORD_BITS + 2;
	localparam int QW = $clog2(NW + 1);

	logic [COORD_BITS-1:0] vx_q [MAX_VERTICES];
	logic [COORD_BITS-1:0] vy_q [MAX_VERTICES];
	logic [COORD_BITS-1:0] cb_q [MAX_VERTICES];
	logic [COORD_BITS-1:0] cur_q, fin_q, lo_q, hi_q, ly_q;
	logic filling_q, done_q;
	logic [CW-1:0] n_q, i_q, cnt_q, k_q;
	logic [1:0] ph_q;
	logic [NW-1:0] num_q, quo_q;
	logic [DW-1:0] den_q;
	logic [NW:0] rem_q;
	logic neg_q;
	logic [QW-1:0] bit_q;
	logic sort_par_q;
	logic [CW-1:0] sort_cnt_q;

	wire [CW-1:0] vc_ext = CW'(vcount);
	wire [CW-1:0] nused = (vcount == 5'd0) ? CW'(1)
		: ((32'(vcount) > MAX_VERTICES) ? CW'(MAX_VERTICES) : vc_ext);
	wire [CW-1:0] jn = (i_q + CW'(1) == n_q) ? '0 : i_q + CW'(1);
	wire [COORD_BITS-1:0] xi = vx_q[i_q[IW-1:0]], yi = vy_q[i_q[IW-1:0]];
	wire [COORD_BITS-1:0] xj = vx_q[jn[IW-1:0]], yj = vy_q[jn[IW-1:0]];
	wire hit = (yi <= ly_q && yj > ly_q) || (yj <= ly_q && yi > ly_q);
	wire [DW-1:0] dx = {1'b0, xj} - {1'b0, xi};
	wire [DW-1:0] dy = {1'b0, yj} - {1'b0, yi};
	wire [DW-1:0] ty = {1'b0, ly_q} - {1'b0, yi};
	wire [NW-1:0] prod = NW'($signed(ty) * $signed(dx));
	wire [NW:0] trial = {rem_q[NW-1:0], num_q[NW-1]};
	wire [NW:0] dext = {{(NW-DW+1){1'b0}}, den_q};
	wire [NW-1:0] qneg = ~quo_q + NW'(1);
	wire [NW-1:0] fq = neg_q ? ((rem_q != '0) ? qneg - NW'(1) : qneg) : quo_q;
	wire [COORD_BITS-1:0] xcr = xi + fq[COORD_BITS-1:0];

	assign need_scan = !filling_q;

	always_ff @(posedge clk) begin
		if (wr_en && 32'(wr_idx) < MAX_VERTICES) begin
			vx_q[IW'(wr_idx)] <= wr_x;
			vy_q[IW'(wr_idx)] <= wr_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0; fin_q <= '0; filling_q <= 1'b0; ph_q <= '0;
			sts <= '0; i_q <= '0; cnt_q <= '0; k_q <= '0; n_q <= '0;
			sort_cnt_q <= '0; sort_par_q <= 1'b0;
		end else begin
			sts <= '0;
			if (cmd.start_scan) begin
				n_q <= nused; i_q <= CW'(1);
				lo_q <= vy_q[0]; hi_q <= vy_q[0];
				ph_q <= 2'd1;
			end else if (ph_q == 2'd1) begin
				if (i_q >= n_q) begin
					cur_q <= lo_q; fin_q <= hi_q; filling_q <= 1'b1;
					ph_q <= 2'd0; sts.scan_done <= 1'b1;
				end else begin
					if (vy_q[i_q[IW-1:0]] < lo_q) lo_q <= vy_q[i_q[IW-1:0]];
					if (vy_q[i_q[IW-1:0]] > hi_q) hi_q <= vy_q[i_q[IW-1:0]];
					i_q <= i_q + CW'(1);
				end
			end
			if (cmd.start_edge) begin
				ly_q <= cur_q; done_q <= (cur_q >= fin_q);
				if (cur_q >= fin_q) filling_q <= 1'b0;
				else cur_q <= cur_q + COORD_BITS'(1);
				n_q <= nused; i_q <= '0; cnt_q <= '0; ph_q <= 2'd2;
			end else if (ph_q == 2'd2) begin
				if (i_q >= n_q) begin
					ph_q <= 2'd0; sts.edge_done <= 1'b1;
				end else if (hit) begin
					neg_q <= prod[NW-1] ^ dy[DW-1];
					num_q <= prod[NW-1] ? ~prod + NW'(1) : prod;
					den_q <= dy[DW-1] ? ~dy + DW'(1) : dy;
					rem_q <= '0; quo_q <= '0; bit_q <= QW'(NW);
					ph_q <= 2'd3;
				end else begin
					i_q <= i_q + CW'(1);
				end
			end else if (ph_q == 2'd3) begin
				if (bit_q == '0) begin
					cb_q[cnt_q[IW-1:0]] <= xcr;
					cnt_q <= cnt_q + CW'(1);
					i_q <= i_q + CW'(1);
					ph_q <= 2'd2;
				end else begin
					num_q <= {num_q[NW-2:0], 1'b0};
					if (trial >= dext) begin
						rem_q <= trial - dext; quo_q <= {quo_q[NW-2:0], 1'b1};
					end else begin
						rem_q <= trial; quo_q <= {quo_q[NW-2:0], 1'b0};
					end
					bit_q <= bit_q - QW'(1);
				end
			end
			if (cmd.start_sort) begin
				sort_cnt_q <= '0; sort_par_q <= 1'b0;
				k_q <= '0;
			end else if (!sts.sort_done && sort_cnt_q <= cnt_q && k_q == '0
				&& !sts.edge_done) begin
				for (int p = 0; p < MAX_VERTICES - 1; p++) begin
					if ((p % 2) == int'(sort_par_q) && CW'(p + 1) < cnt_q
						&& cb_q[p] > cb_q[p+1]) begin
						cb_q[p] <= cb_q[p+1]; cb_q[p+1] <= cb_q[p];
					end
				end
				sort_par_q <= !sort_par_q;
				sort_cnt_q <= sort_cnt_q + CW'(1);
				if (sort_cnt_q == cnt_q) sts.sort_done <= 1'b1;
			end
			if (cmd.emit) begin
				k_q <= emit_more ? k_q + CW'(1) : '0;
				if (!emit_more) sort_cnt_q <= CW'(MAX_VERTICES);
			end
			if (cmd.start_edge) sort_cnt_q <= CW'(MAX_VERTICES);
		end
	end

	wire [CW-1:0] spans = cnt_q >> 1;
	assign emit_more = (k_q + CW'(1) < spans);
	wire [IW-1:0] ia = IW'({k_q, 1'b0});
	wire [IW-1:0] ib = IW'({k_q, 1'b1});
	assign o_y = ly_q;
	assign o_sv = (spans != '0);
	assign o_xs = o_sv ? cb_q[ia] : '0;
	assign o_xe = o_sv ? cb_q[ib] : '0;
	assign o_last = !emit_more;
	assign o_done = done_q;
endmodule
`default_nettype wire

// File: src/scanline_polygon_span_fill.sv
// Top level of the scanline polygon span fill block.
// Depends on spf_pkg, spf_if, spf_ctrl and spf_dp.
//
//   channel  dir  payload
//   cfg      in   vertex_count
//   in_ch    in   command, vertex_index, vertex_x, vertex_y
//   out_ch   out  span_y, span_x_start, span_x_end, span_valid, last, fill_done
//
// A fill line finds the crossings (serial divider, 22 steps each), sorts them in
// one more pass than there are crossings and emits one span per cycle while the
// output register is free; the first line of a fill also runs the y scan. Reset sets
// vertex_count to 3 and ends any fill; vertex slots hold no value until written.
// Results wait in an output register; emission stalls while it is full and unread.
`default_nettype none
module scanline_polygon_span_fill import spf_pkg::*; #(
	parameter int MAX_VERTICES = 16,
	parameter int COORD_BITS = 10
) (
	input wire logic clk,
	input wire logic arst_n,
	spf_if.sink cfg,
	spf_if.sink in_ch,
	spf_if.source out_ch
);
	logic [4:0] vcount_q;
	logic busy, need_scan, emit_more;
	spf_cmd_t cmd;
	spf_sts_t sts;
	logic [COORD_BITS-1:0] o_y, o_xs, o_xe;
	logic o_sv, o_last, o_done;
	logic ov_q;

	wire cmd_bit = in_ch.data[2*COORD_BITS+4];
	wire [3:0] idx = in_ch.data[2*COORD_BITS+3 -: 4];
	wire [COORD_BITS-1:0] wx = in_ch.data[2*COORD_BITS-1 -: COORD_BITS];
	wire [COORD_BITS-1:0] wy = in_ch.data[COORD_BITS-1:0];

	assign cfg.ready = 1'b1;
	assign in_ch.ready = !busy;
	wire acc = in_ch.valid && in_ch.ready;
	wire out_free = !ov_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= 5'd3;
			ov_q <= 1'b0;
		end else begin
			if (cfg.valid) vcount_q <= cfg.data[4:0];
			if (cmd.emit) ov_q <= 1'b1;
			else if (out_ch.ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit)
			out_ch.data <= {o_y, o_xs, o_xe, o_sv, o_last, o_done};
	end
	assign out_ch.valid = ov_q;

	spf_ctrl u_ctrl (
		.clk, .arst_n,
		.fill_req(acc && cmd_bit == CMD_FILL),
		.need_scan, .out_free, .emit_more, .sts, .cmd, .busy
	);

	spf_dp #(.MAX_VERTICES(MAX_VERTICES), .COORD_BITS(COORD_BITS)) u_dp (
		.clk, .arst_n,
		.wr_en(acc && cmd_bit == CMD_WRITE),
		.wr_idx(idx), .wr_x(wx), .wr_y(wy), .vcount(vcount_q),
		.cmd, .sts, .need_scan, .emit_more,
		.o_y, .o_xs, .o_xe, .o_sv, .o_last, .o_done
	);
endmodule
`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for scanline_polygon_span_fill: vertex writes and fill
// transactions are driven on in_ch, spans are predicted and compared on out_ch.
// Depends on spf_pkg, spf_if and scanline_polygon_span_fill from the RTL.
`timescale 1ns / 1ps
module tb_top import spf_pkg::*; ();

	typedef struct packed {
		logic       command;
		logic [3:0] vertex_index;
		logic [9:0] vertex_x;
		logic [9:0] vertex_y;
	} poly_cmd_t;

	typedef struct packed {
		logic [9:0] span_y;
		logic [9:0] span_x_start;
		logic [9:0] span_x_end;
		logic       span_valid;
		logic       last;
		logic       fill_done;
	} span_t;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE = 600;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	spf_if #(.W(5))  cfg_bus();
	spf_if #(.W(25)) cmd_bus();
	spf_if #(.W(33)) span_bus();

	scanline_polygon_span_fill u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_bus),
		.in_ch(cmd_bus),
		.out_ch(span_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	poly_cmd_t pending_cmds[$];
	span_t     expected_spans[$];
	poly_cmd_t cur_cmd;
	bit        sending = 0;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	int        hold_req = 0;
	int        hold_seen = 0;
	int        hold_left = 0;
	int        mismatches = 0;
	int        spans_seen = 0;
	int        fills_sent = 0;
	int        writes_sent = 0;
	int        cycles = 0;

	logic [9:0] shadow_x[16];
	logic [9:0] shadow_y[16];
	logic [4:0] shadow_count = 5'd3;
	logic [9:0] line_now = '0;
	logic [9:0] line_top = '0;
	bit         in_fill = 0;

	function automatic int active_vertices();
		if (shadow_count == 0)
			return 1;
		if (shadow_count > 16)
			return 16;
		return int'(shadow_count);
	endfunction

	function automatic longint floor_quot(longint num, longint den);
		longint q;
		q = num / den;
		if ((num % den) != 0 && ((num < 0) != (den < 0)))
			q -= 1;
		return q;
	endfunction

	function automatic void predict_spans(poly_cmd_t c);
		int n;
		int cnt;
		int j;
		logic [9:0] y;
		logic [9:0] xs[16];
		logic [9:0] v;
		longint xi, yi, xj, yj, ly;
		bit done;
		span_t s;
		if (c.command == CMD_WRITE) begin
			shadow_x[c.vertex_index] = c.vertex_x;
			shadow_y[c.vertex_index] = c.vertex_y;
			return;
		end
		n = active_vertices();
		if (!in_fill) begin
			line_now = shadow_y[0];
			line_top = shadow_y[0];
			for (int k = 1; k < n; k++) begin
				if (shadow_y[k] < line_now) line_now = shadow_y[k];
				if (shadow_y[k] > line_top) line_top = shadow_y[k];
			end
			in_fill = 1;
		end
		y = line_now;
		done = (line_now >= line_top);
		if (done)
			in_fill = 0;
		else
			line_now = line_now + 10'd1;
		cnt = 0;
		ly = y;
		for (int i = 0; i < n; i++) begin
			j = (i + 1 == n) ? 0 : i + 1;
			xi = shadow_x[i];
			yi = shadow_y[i];
			xj = shadow_x[j];
			yj = shadow_y[j];
			if ((yi <= ly && yj > ly) || (yj <= ly && yi > ly)) begin
				xs[cnt] = 10'(xi + floor_quot((ly - yi) * (xj - xi), yj - yi));
				cnt++;
			end
		end
		for (int i = 1; i < cnt; i++) begin
			v = xs[i];
			j = i;
			while (j > 0 && xs[j - 1] > v) begin
				xs[j] = xs[j - 1];
				j--;
			end
			xs[j] = v;
		end
		if (cnt / 2 == 0) begin
			s = '{y, 10'd0, 10'd0, 1'b0, 1'b1, done};
			expected_spans.push_back(s);
		end else begin
			for (int k = 0; k < cnt / 2; k++) begin
				s = '{y, xs[2*k], xs[2*k+1], 1'b1, (k + 1 == cnt / 2), done};
				expected_spans.push_back(s);
			end
		end
	endfunction

	// Driver: predictions are made at the edge where the transaction is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_bus.valid <= 1'b0;
			cmd_bus.data <= '0;
			sending = 0;
		end else begin
			if (cmd_bus.valid && cmd_bus.ready) begin
				predict_spans(cur_cmd);
				if (cur_cmd.command == CMD_FILL) fills_sent++;
				else writes_sent++;
				sending = 0;
			end
			if (!sending && pending_cmds.size() > 0 &&
			    $urandom_range(99) >= send_idle_pct) begin
				cur_cmd = pending_cmds.pop_front();
				cmd_bus.valid <= 1'b1;
				cmd_bus.data <= cur_cmd;
				sending = 1;
			end else if (!sending) begin
				cmd_bus.valid <= 1'b0;
				cmd_bus.data <= 25'($urandom);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (hold_left > 0)
			hold_left <= hold_left - 1;
		else if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= 3000;
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Monitor: compares each accepted span with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		span_t got;
		span_t want;
		if (!arst_n) begin
			span_bus.ready <= 1'b0;
		end else begin
			if (span_bus.valid && span_bus.ready) begin
				got = span_bus.data;
				spans_seen++;
				if (expected_spans.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected span transaction %p", got);
				end else begin
					want = expected_spans.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("span mismatch: expected %p, got %p", want, got);
					end
				end
			end
			span_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic add_cmd(int fill, int idx, int x, int y);
		poly_cmd_t c;
		c.command = (fill != 0) ? CMD_FILL : CMD_WRITE;
		c.vertex_index = 4'(idx);
		c.vertex_x = 10'(x);
		c.vertex_y = 10'(y);
		pending_cmds.push_back(c);
	endtask

	task automatic drain();
		while (pending_cmds.size() > 0 || sending || expected_spans.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_count(logic [4:0] value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.data <= value;
		do @(posedge clk); while (!cfg_bus.ready);
		shadow_count = value;
		cfg_bus.valid <= 1'b0;
	endtask

	initial begin
		int counts[8];
		int n, base, span, phase, rand_items;
		counts = '{16, 5, 31, 3, 17, 8, 0, 4};
		cfg_bus.valid = 1'b0;
		cfg_bus.data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Triangle whose apex on its lowest line gives a zero-length span.
		add_cmd(0, 0, 0, 0);
		add_cmd(0, 1, 1023, 2);
		add_cmd(0, 2, 512, 4);
		for (int i = 3; i < 16; i++)
			add_cmd(0, i, (i == 15) ? 1023 : i * 60, i % 5);
		for (int i = 0; i < 5; i++)
			add_cmd(1, 0, 0, 0);
		drain();
		write_count(5'd0);
		add_cmd(0, 0, 1023, 1023);
		add_cmd(1, 0, 0, 0);
		drain();

		phase = 0;
		rand_items = 0;
		while (rand_items < 100) begin
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
				default: begin send_idle_pct = 6; recv_stall_pct = 6; end
			endcase
			write_count(5'(counts[phase % 8]));
			n = active_vertices();
			base = $urandom_range(1017);
			span = 0;
			for (int i = 0; i < n; i++) begin
				int y;
				y = base + $urandom_range(6);
				if (y - base > span) span = y - base;
				add_cmd(0, i,
					(phase % 5 == 0) ? ((i % 2) ? 1023 : 0) : $urandom_range(1023), y);
				rand_items++;
			end
			if (phase == 2)
				hold_req++;
			for (int i = 0; i < span + 1 + $urandom_range(2); i++) begin
				add_cmd(1, $urandom_range(15), $urandom_range(1023), $urandom_range(1023));
				rand_items++;
				if ($urandom_range(9) == 0) begin
					add_cmd(0, $urandom_range(n - 1), $urandom_range(1023),
						base + $urandom_range(6));
					rand_items++;
				end
			end
			drain();
			phase++;
		end

		$display("Covered %0d vertex writes and %0d fill lines over %0d phases,", writes_sent,
			fills_sent, phase + 2);
		$display("checking %0d span transactions with %0d mismatches.", spans_seen, mismatches);
		if (mismatches == 0 && expected_spans.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
